>>> hw/rtl/rpd_pkg.sv
// Shared types and constants for the response packet deframer.
// Used by rpd_collector and response_packet_deframer; depends on nothing.

package rpd_pkg;

    localparam int FRAME_BYTES = 12;
    localparam int PHASE_W     = 4;

    typedef logic [PHASE_W-1:0] phase_t;

    // Frame byte positions. Phase zero means hunting for the start byte.
    localparam phase_t PH_HUNT     = phase_t'(0);
    localparam phase_t PH_START2   = phase_t'(1);
    localparam phase_t PH_DEV_LO   = phase_t'(2);
    localparam phase_t PH_DEV_HI   = phase_t'(3);
    localparam phase_t PH_PARAM0   = phase_t'(4);
    localparam phase_t PH_PARAM1   = phase_t'(5);
    localparam phase_t PH_PARAM2   = phase_t'(6);
    localparam phase_t PH_PARAM3   = phase_t'(7);
    localparam phase_t PH_ACK      = phase_t'(8);
    localparam phase_t PH_ACK_HI   = phase_t'(9);
    localparam phase_t PH_SUM_LO   = phase_t'(10);
    localparam phase_t PH_LAST     = phase_t'(FRAME_BYTES - 1);
    localparam phase_t PH_LIMIT    = phase_t'(FRAME_BYTES);

    localparam logic [7:0] ACK_CODE     = 8'h30;
    localparam logic [7:0] NACK_CODE    = 8'h31;
    localparam logic [7:0] ACK_HI_CODE  = 8'h00;
    localparam logic [7:0] PARAM_HI_OK  = 8'h01;
    localparam logic [7:0] ERR_MAX_CODE = 8'h12;

    localparam logic [4:0] ERR_INVALID = 5'd19;

    // Configuration register indexes and reset values.
    typedef enum logic [1:0] {
        CFG_START_BYTE_ONE = 2'd0,
        CFG_START_BYTE_TWO = 2'd1,
        CFG_DEVICE_ID_LOW  = 2'd2,
        CFG_DEVICE_ID_HIGH = 2'd3
    } cfg_index_t;

    localparam logic [7:0] START_BYTE_ONE_RST = 8'h55;
    localparam logic [7:0] START_BYTE_TWO_RST = 8'hAA;
    localparam logic [7:0] DEVICE_ID_LOW_RST  = 8'h01;
    localparam logic [7:0] DEVICE_ID_HIGH_RST = 8'h00;

    typedef struct packed {
        logic [7:0] start_byte_one;
        logic [7:0] start_byte_two;
        logic [7:0] device_id_low;
        logic [7:0] device_id_high;
    } rpd_cfg_t;

    typedef struct packed {
        logic        ack;
        logic [4:0]  error_code;
        logic [31:0] param_value;
        logic        header_ok;
        logic        ack_field_ok;
        logic        checksum_ok;
    } rpd_result_t;

endpackage

>>> hw/rtl/rpd_collector.sv
// Frame collector: tracks the byte position, checks header and ack fields,
// accumulates the checksum and builds the result on the last frame byte.
// Depends on rpd_pkg.

module rpd_collector (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    input  rpd_pkg::rpd_cfg_t    cfg,
    output logic                 res_valid,
    output rpd_pkg::rpd_result_t res
);

    rpd_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     sum_reg, sum_next;
    logic [31:0]     param_reg, param_next;
    logic            header_good_reg, header_good_next;
    logic [7:0]      ack_seen_reg, ack_seen_next;
    logic            ack_high_good_reg, ack_high_good_next;
    logic            sum_low_match_reg, sum_low_match_next;

    logic hunting;
    logic last_byte;

    assign hunting   = (phase_reg == rpd_pkg::PH_HUNT) || (phase_reg >= rpd_pkg::PH_LIMIT);
    assign last_byte = !hunting && (phase_reg == rpd_pkg::PH_LAST);
    assign res_valid = step && last_byte;

    always_comb begin
        phase_next         = phase_reg;
        sum_next           = sum_reg;
        param_next         = param_reg;
        header_good_next   = header_good_reg;
        ack_seen_next      = ack_seen_reg;
        ack_high_good_next = ack_high_good_reg;
        sum_low_match_next = sum_low_match_reg;

        if (step) begin
            if (hunting) begin
                if (rx_byte == cfg.start_byte_one) begin
                    phase_next         = rpd_pkg::PH_START2;
                    sum_next           = {8'h00, rx_byte};
                    param_next         = '0;
                    header_good_next   = 1'b1;
                    ack_seen_next      = '0;
                    ack_high_good_next = 1'b1;
                    sum_low_match_next = 1'b0;
                end else begin
                    phase_next = rpd_pkg::PH_HUNT;
                end
            end else begin
                if (phase_reg < rpd_pkg::PH_SUM_LO) begin
                    sum_next = sum_reg + {8'h00, rx_byte};
                end
                unique case (phase_reg)
                    rpd_pkg::PH_START2: begin
                        if (rx_byte != cfg.start_byte_two) header_good_next = 1'b0;
                    end
                    rpd_pkg::PH_DEV_LO: begin
                        if (rx_byte != cfg.device_id_low) header_good_next = 1'b0;
                    end
                    rpd_pkg::PH_DEV_HI: begin
                        if (rx_byte != cfg.device_id_high) header_good_next = 1'b0;
                    end
                    rpd_pkg::PH_PARAM0, rpd_pkg::PH_PARAM1,
                    rpd_pkg::PH_PARAM2, rpd_pkg::PH_PARAM3: begin
                        // Little-endian: each new byte enters at the top.
                        param_next = {rx_byte, param_reg[31:8]};
                    end
                    rpd_pkg::PH_ACK: begin
                        ack_seen_next = rx_byte;
                    end
                    rpd_pkg::PH_ACK_HI: begin
                        ack_high_good_next = (rx_byte == rpd_pkg::ACK_HI_CODE);
                    end
                    rpd_pkg::PH_SUM_LO: begin
                        sum_low_match_next = (rx_byte == sum_reg[7:0]);
                    end
                    default: begin
                    end
                endcase
                if (last_byte) begin
                    phase_next = rpd_pkg::PH_HUNT;
                end else begin
                    phase_next = phase_reg + rpd_pkg::phase_t'(1);
                end
            end
        end
    end

    // Result fields come straight from the collected frame and the last byte.
    always_comb begin
        res.ack         = (ack_seen_reg == rpd_pkg::ACK_CODE);
        res.param_value = param_reg;
        if ((param_reg[15:8] == rpd_pkg::PARAM_HI_OK) &&
            (param_reg[7:0] <= rpd_pkg::ERR_MAX_CODE)) begin
            res.error_code = param_reg[4:0];
        end else begin
            res.error_code = rpd_pkg::ERR_INVALID;
        end
        res.header_ok    = header_good_reg;
        res.ack_field_ok = ((ack_seen_reg == rpd_pkg::ACK_CODE) ||
                            (ack_seen_reg == rpd_pkg::NACK_CODE)) && ack_high_good_reg;
        res.checksum_ok  = sum_low_match_reg && (rx_byte == sum_reg[15:8]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rpd_pkg::PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg           <= sum_next;
        param_reg         <= param_next;
        header_good_reg   <= header_good_next;
        ack_seen_reg      <= ack_seen_next;
        ack_high_good_reg <= ack_high_good_next;
        sum_low_match_reg <= sum_low_match_next;
    end

    a_phase_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < rpd_pkg::PH_LIMIT)
        else $error("frame phase left its range");

    a_result_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (phase_reg == rpd_pkg::PH_HUNT))
        else $error("phase did not return to hunting after a result");

    a_no_step_holds_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(phase_reg))
        else $error("phase moved without an accepted byte");

    a_start_opens_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && hunting && (rx_byte == cfg.start_byte_one)) |=>
        (phase_reg == rpd_pkg::PH_START2))
        else $error("start byte did not open a frame");

endmodule

>>> hw/rtl/response_packet_deframer.sv
// Response packet deframer: 12-byte frame collector with a registered result.
// The result is registered: it appears in the cycle after the last frame byte is accepted.
// Throughput: one byte per cycle; s_ready drops only while a result waits
// and m_ready is low. Reset (aresetn, synchronous, active low) returns to
// hunting for the start byte and restores the configuration defaults.
// Depends on rpd_pkg and rpd_collector.

module response_packet_deframer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ack,
    output logic [4:0]  m_error_code,
    output logic [31:0] m_param_value,
    output logic        m_header_ok,
    output logic        m_ack_field_ok,
    output logic        m_checksum_ok
);

    rpd_pkg::rpd_cfg_t    cfg_reg;
    rpd_pkg::rpd_result_t res;
    rpd_pkg::rpd_result_t res_hold_reg;
    logic                 res_valid;
    logic                 step;
    logic                 m_valid_reg, m_valid_next;

    // A new request is taken whenever the output slot is free or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte_one <= rpd_pkg::START_BYTE_ONE_RST;
            cfg_reg.start_byte_two <= rpd_pkg::START_BYTE_TWO_RST;
            cfg_reg.device_id_low  <= rpd_pkg::DEVICE_ID_LOW_RST;
            cfg_reg.device_id_high <= rpd_pkg::DEVICE_ID_HIGH_RST;
        end else if (cfg_we) begin
            unique case (rpd_pkg::cfg_index_t'(cfg_index))
                rpd_pkg::CFG_START_BYTE_ONE: cfg_reg.start_byte_one <= cfg_wdata;
                rpd_pkg::CFG_START_BYTE_TWO: cfg_reg.start_byte_two <= cfg_wdata;
                rpd_pkg::CFG_DEVICE_ID_LOW:  cfg_reg.device_id_low  <= cfg_wdata;
                rpd_pkg::CFG_DEVICE_ID_HIGH: cfg_reg.device_id_high <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    rpd_collector u_collector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .rx_byte   (s_rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_hold_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_ack          = res_hold_reg.ack;
    assign m_error_code   = res_hold_reg.error_code;
    assign m_param_value  = res_hold_reg.param_value;
    assign m_header_ok    = res_hold_reg.header_ok;
    assign m_ack_field_ok = res_hold_reg.ack_field_ok;
    assign m_checksum_ok  = res_hold_reg.checksum_ok;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !res_valid)
        else $error("result produced while the output slot was still full");

    a_result_loads_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> m_valid_reg)
        else $error("result did not reach the output register");

    a_error_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_error_code <= rpd_pkg::ERR_INVALID))
        else $error("error code out of range");

endmodule

>>> test/response_packet_deframer_tb.sv
// Self-checking testbench for response_packet_deframer: a directed table, then random
// byte streams, with an in-bench frame predictor and random idling on both sides.
// Depends on rpd_pkg and the deframer RTL; reads no files.

module response_packet_deframer_tb;

    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_ITEMS    = 240;
    localparam int SETTLE_CYCLES  = 3;
    localparam int END_DRAIN      = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                cfg_we    = 1'b0;
    rpd_pkg::cfg_index_t cfg_index = rpd_pkg::CFG_START_BYTE_ONE;
    logic [7:0]          cfg_wdata = 8'h00;
    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic [7:0]          s_rx_byte = 8'h00;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic                m_ack;
    logic [4:0]          m_error_code;
    logic [31:0]         m_param_value;
    logic                m_header_ok;
    logic                m_ack_field_ok;
    logic                m_checksum_ok;

    typedef struct {
        logic [7:0]           rx_byte;
        bit                   typed;
        rpd_pkg::rpd_result_t result;
    } directed_row_t;

    directed_row_t        directed_rows[$];
    rpd_pkg::rpd_result_t pending_results[$];
    logic [7:0]           byte_stream[$];

    // Frame collector state of the predictor, with its own copy of the registers.
    rpd_pkg::rpd_cfg_t cfg_model;
    rpd_pkg::phase_t   frame_phase;
    logic [15:0]       frame_sum;
    logic [31:0]       param_bytes;
    logic              header_match;
    logic [7:0]        ack_code_seen;
    logic              ack_hi_zero;
    logic              sum_lo_match;

    int                   mismatch_count     = 0;
    int                   quiet_cycles       = 0;
    int                   sender_idle_pct    = 0;
    int                   receiver_stall_pct = 0;
    int                   stall_left         = 0;
    rpd_pkg::rpd_result_t result_head;

    response_packet_deframer DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ack          (m_ack),
        .m_error_code   (m_error_code),
        .m_param_value  (m_param_value),
        .m_header_ok    (m_header_ok),
        .m_ack_field_ok (m_ack_field_ok),
        .m_checksum_ok  (m_checksum_ok)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s at %0t: got 0x%0h, want 0x%0h", what, $time, got, want);
        mismatch_count++;
    endtask

    function void clear_frame();
        frame_phase   = rpd_pkg::PH_HUNT;
        frame_sum     = '0;
        param_bytes   = '0;
        header_match  = 1'b1;
        ack_code_seen = '0;
        ack_hi_zero   = 1'b1;
        sum_lo_match  = 1'b0;
    endfunction

    // Advances the predictor by one received byte; returns 1 when the byte closes a frame.
    function automatic bit deframe_byte(input logic [7:0] b,
                                        output rpd_pkg::rpd_result_t res);
        rpd_pkg::phase_t ph;
        logic [7:0]      code_lo;
        logic [7:0]      code_hi;
        ph  = frame_phase;
        res = '0;
        if (ph == rpd_pkg::PH_HUNT || ph >= rpd_pkg::PH_LIMIT) begin
            if (b == cfg_model.start_byte_one) begin
                clear_frame();
                frame_sum   = {8'h00, b};
                frame_phase = rpd_pkg::PH_START2;
            end else begin
                frame_phase = rpd_pkg::PH_HUNT;
            end
            return 1'b0;
        end
        if (ph < rpd_pkg::PH_SUM_LO) begin
            frame_sum = frame_sum + {8'h00, b};
        end
        case (ph)
            rpd_pkg::PH_START2: if (b != cfg_model.start_byte_two) header_match = 1'b0;
            rpd_pkg::PH_DEV_LO: if (b != cfg_model.device_id_low) header_match = 1'b0;
            rpd_pkg::PH_DEV_HI: if (b != cfg_model.device_id_high) header_match = 1'b0;
            rpd_pkg::PH_PARAM0, rpd_pkg::PH_PARAM1,
            rpd_pkg::PH_PARAM2, rpd_pkg::PH_PARAM3: begin
                param_bytes = {b, param_bytes[31:8]};
            end
            rpd_pkg::PH_ACK:    ack_code_seen = b;
            rpd_pkg::PH_ACK_HI: ack_hi_zero = (b == rpd_pkg::ACK_HI_CODE);
            rpd_pkg::PH_SUM_LO: sum_lo_match = (b == frame_sum[7:0]);
            default: ;
        endcase
        if (ph < rpd_pkg::PH_LAST) begin
            frame_phase = rpd_pkg::phase_t'(ph + 1);
            return 1'b0;
        end
        code_lo          = param_bytes[7:0];
        code_hi          = param_bytes[15:8];
        res.ack          = (ack_code_seen == rpd_pkg::ACK_CODE);
        res.error_code   = (code_hi == rpd_pkg::PARAM_HI_OK &&
                            code_lo <= rpd_pkg::ERR_MAX_CODE) ?
                           code_lo[4:0] : rpd_pkg::ERR_INVALID;
        res.param_value  = param_bytes;
        res.header_ok    = header_match;
        res.ack_field_ok = (ack_code_seen == rpd_pkg::ACK_CODE ||
                            ack_code_seen == rpd_pkg::NACK_CODE) && ack_hi_zero;
        res.checksum_ok  = sum_lo_match && (b == frame_sum[15:8]);
        clear_frame();
        return 1'b1;
    endfunction

    // Presents one request and holds it until accepted, then maybe idles a burst.
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input rpd_pkg::rpd_result_t typed_res);
        rpd_pkg::rpd_result_t res;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        if (deframe_byte(b, res)) begin
            pending_results.push_back(typed ? typed_res : res);
        end
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // Mostly well-formed frames with random content; some noise and cut-short frames.
    task automatic queue_random_bytes();
        logic [7:0]  frame [rpd_pkg::FRAME_BYTES];
        logic [15:0] sum;
        int          keep;
        int          pick;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 5)) byte_stream.push_back(8'($urandom));
        end else begin
            frame[0] = cfg_model.start_byte_one;
            frame[1] = ($urandom_range(0, 5) != 0) ? cfg_model.start_byte_two : 8'($urandom);
            frame[2] = ($urandom_range(0, 5) != 0) ? cfg_model.device_id_low : 8'($urandom);
            frame[3] = ($urandom_range(0, 5) != 0) ? cfg_model.device_id_high : 8'($urandom);
            case ($urandom_range(0, 3))
                0: frame[4] = 8'($urandom);
                1: frame[4] = rpd_pkg::ERR_MAX_CODE + 8'($urandom_range(0, 1));
                default: frame[4] = 8'($urandom_range(0, 18));
            endcase
            frame[5] = ($urandom_range(0, 4) != 0) ? rpd_pkg::PARAM_HI_OK : 8'($urandom);
            frame[6] = 8'($urandom);
            frame[7] = 8'($urandom);
            case ($urandom_range(0, 3))
                0: frame[8] = rpd_pkg::NACK_CODE;
                1: frame[8] = 8'($urandom);
                default: frame[8] = rpd_pkg::ACK_CODE;
            endcase
            frame[9] = ($urandom_range(0, 4) != 0) ? rpd_pkg::ACK_HI_CODE : 8'($urandom);
            sum = '0;
            for (int i = 0; i < 10; i++) begin
                sum = sum + {8'h00, frame[i]};
            end
            frame[10] = sum[7:0];
            frame[11] = sum[15:8];
            if ($urandom_range(0, 5) == 0) begin
                pick        = 10 + $urandom_range(0, 1);
                frame[pick] = frame[pick] ^ 8'(1 << $urandom_range(0, 7));
            end
            keep = ($urandom_range(0, 14) == 0) ?
                   $urandom_range(1, rpd_pkg::FRAME_BYTES - 1) : rpd_pkg::FRAME_BYTES;
            for (int i = 0; i < keep; i++) begin
                byte_stream.push_back(frame[i]);
            end
        end
    endtask

    // Result side: checks each accepted result and stalls in random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_param_value, 32'h0);
            end else begin
                result_head = pending_results.pop_front();
                if (m_ack !== result_head.ack)
                    report_mismatch("ack", 32'(m_ack), 32'(result_head.ack));
                if (m_error_code !== result_head.error_code)
                    report_mismatch("error_code", 32'(m_error_code),
                                    32'(result_head.error_code));
                if (m_param_value !== result_head.param_value)
                    report_mismatch("param_value", m_param_value, result_head.param_value);
                if (m_header_ok !== result_head.header_ok)
                    report_mismatch("header_ok", 32'(m_header_ok),
                                    32'(result_head.header_ok));
                if (m_ack_field_ok !== result_head.ack_field_ok)
                    report_mismatch("ack_field_ok", 32'(m_ack_field_ok),
                                    32'(result_head.ack_field_ok));
                if (m_checksum_ok !== result_head.checksum_ok)
                    report_mismatch("checksum_ok", 32'(m_checksum_ok),
                                    32'(result_head.checksum_ok));
            end
        end
        // A burst left over from an earlier phase is ignored while stalling is off.
        if (stall_left > 0 && receiver_stall_pct > 0) begin
            m_ready    <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 99) < receiver_stall_pct) begin
            m_ready    <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        logic [7:0] reg_values [4];
        logic [7:0] next_byte;
        int         sent_in_phase;

        cfg_model = {rpd_pkg::START_BYTE_ONE_RST, rpd_pkg::START_BYTE_TWO_RST,
                     rpd_pkg::DEVICE_ID_LOW_RST, rpd_pkg::DEVICE_ID_HIGH_RST};
        clear_frame();

        // Typed results list ack, error_code, param_value, header_ok, ack_field_ok,
        // checksum_ok. The first frame carries a start code inside its parameter.
        directed_rows.push_back('{8'hFF, 1'b0, '0});
        directed_rows.push_back('{8'h55, 1'b0, '0});
        directed_rows.push_back('{8'hAA, 1'b0, '0});
        directed_rows.push_back('{8'h01, 1'b0, '0});
        directed_rows.push_back('{8'h00, 1'b0, '0});
        directed_rows.push_back('{8'h12, 1'b0, '0});
        directed_rows.push_back('{8'h01, 1'b0, '0});
        directed_rows.push_back('{8'h55, 1'b0, '0});
        directed_rows.push_back('{8'h00, 1'b0, '0});
        directed_rows.push_back('{8'h30, 1'b0, '0});
        directed_rows.push_back('{8'h00, 1'b0, '0});
        directed_rows.push_back('{8'h98, 1'b0, '0});
        directed_rows.push_back('{8'h01, 1'b1,
                                  {1'b1, 5'd18, 32'h0055_0112, 1'b1, 1'b1, 1'b1}});
        directed_rows.push_back('{8'h55, 1'b0, '0});
        directed_rows.push_back('{8'h00, 1'b0, '0});
        directed_rows.push_back('{8'hFF, 1'b0, '0});
        directed_rows.push_back('{8'hFF, 1'b0, '0});
        directed_rows.push_back('{8'hFF, 1'b0, '0});
        directed_rows.push_back('{8'hFF, 1'b0, '0});
        directed_rows.push_back('{8'hFF, 1'b0, '0});
        directed_rows.push_back('{8'hFF, 1'b0, '0});
        directed_rows.push_back('{8'h31, 1'b0, '0});
        directed_rows.push_back('{8'hFF, 1'b0, '0});
        directed_rows.push_back('{8'h00, 1'b0, '0});
        directed_rows.push_back('{8'h00, 1'b1,
                                  {1'b0, rpd_pkg::ERR_INVALID, 32'hFFFF_FFFF,
                                   1'b0, 1'b0, 1'b0}});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        sender_idle_pct    = 20;
        receiver_stall_pct = 20;
        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].rx_byte, directed_rows[i].typed,
                      directed_rows[i].result);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            // Hold requests until every result is out, then rewrite the registers.
            // A phase may end mid-frame, so the write lands inside a frame.
            s_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);

            case (p)
                0: begin
                    reg_values         = '{8'h00, 8'h00, 8'h00, 8'h00};
                    sender_idle_pct    = 25;
                    receiver_stall_pct = 25;
                end
                1: begin
                    reg_values         = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 45;
                end
                2: begin
                    reg_values         = '{rpd_pkg::START_BYTE_ONE_RST,
                                           rpd_pkg::START_BYTE_TWO_RST,
                                           rpd_pkg::DEVICE_ID_LOW_RST,
                                           rpd_pkg::DEVICE_ID_HIGH_RST};
                    sender_idle_pct    = 40;
                    receiver_stall_pct = 0;
                end
                default: begin
                    foreach (reg_values[r]) reg_values[r] = 8'($urandom);
                    sender_idle_pct    = (p == PHASE_COUNT - 1) ? 0 : 15;
                    receiver_stall_pct = (p == PHASE_COUNT - 1) ? 0 : 15;
                end
            endcase

            for (int r = 0; r < 4; r++) begin
                cfg_we    <= 1'b1;
                cfg_index <= rpd_pkg::cfg_index_t'(r);
                cfg_wdata <= reg_values[r];
                @(posedge aclk);
                case (rpd_pkg::cfg_index_t'(r))
                    rpd_pkg::CFG_START_BYTE_ONE: cfg_model.start_byte_one = reg_values[r];
                    rpd_pkg::CFG_START_BYTE_TWO: cfg_model.start_byte_two = reg_values[r];
                    rpd_pkg::CFG_DEVICE_ID_LOW:  cfg_model.device_id_low  = reg_values[r];
                    rpd_pkg::CFG_DEVICE_ID_HIGH: cfg_model.device_id_high = reg_values[r];
                    default: ;
                endcase
            end
            cfg_we <= 1'b0;

            sent_in_phase = 0;
            while (sent_in_phase < PHASE_ITEMS) begin
                if (byte_stream.size() == 0) begin
                    queue_random_bytes();
                end
                next_byte = byte_stream.pop_front();
                send_byte(next_byte, 1'b0, '0);
                sent_in_phase++;
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (END_DRAIN) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
